// ----- design/hexdmp_pkg.sv -----
// package: shared constants, types and helpers for the hex dump parser
package hexdmp_pkg;

  // largest number of bytes accepted in one string
  localparam int unsigned MaxBytes = 128;

  localparam int unsigned CharW  = 8;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 8;

  typedef logic [CharW-1:0]  char_t;
  typedef logic [ByteW-1:0]  byte_t;
  typedef logic [CountW-1:0] count_t;

  // final status codes of a string
  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StOverflow    = 3'd1,
    StMidByte     = 3'd2,
    StBadHex      = 3'd3,
    StTooShort    = 3'd4,
    StLenMismatch = 3'd5
  } status_e;

  // result kinds
  typedef enum logic {
    KindData   = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  // character constants
  localparam char_t ChNul   = 8'h00;
  localparam char_t ChSpace = 8'h20;

  // opcode length class in bits 6:5
  localparam logic [1:0] LenClass2   = 2'b00;
  localparam logic [1:0] LenClass4   = 2'b01;
  localparam logic [1:0] LenClass6   = 2'b10;
  localparam logic [1:0] LenClassVar = 2'b11;

  // hex digit decode: bit 4 is the valid flag, bits 3:0 the nibble
  function automatic logic [4:0] hex_nibble(input char_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- design/hexdmp_if.sv -----
// interfaces: character input channel and result output channel

interface hexdmp_char_if;
  import hexdmp_pkg::*;

  logic  valid;
  logic  ready;
  char_t char_code;

  modport source (output valid, output char_code, input ready);
  modport sink (input valid, input char_code, output ready);
endinterface

interface hexdmp_res_if;
  import hexdmp_pkg::*;

  logic    valid;
  logic    ready;
  kind_e   result_kind;
  byte_t   data_byte;
  status_e status;
  count_t  byte_count;

  modport source (
    output valid, output result_kind, output data_byte, output status,
    output byte_count, input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input status,
    input byte_count, output ready
  );
endinterface

// ----- design/hex_dump_message_parser.sv -----
// top level: hex dump character parser with message length check
//
// char_i carries one character per transaction; a zero character ends
// the string. Every pair of hex digits yields a data result on res_o
// (result_kind 0, data_byte, running byte_count). Each string gets one
// status result (result_kind 1), at its zero or at its error: ok,
// overflow, ends mid byte, bad hex, too short or length mismatch. After
// an error the rest of the string up to its zero is dropped without results.
// A result appears on res_o in the cycle after the character that
// causes it is taken. Throughput: one character per cycle while res_o
// does not stall; the phase update and the length check sit between
// the character and the single result register.
// The input is ready whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver holds the pending
// result and stops input after one held result.
// Reset clears the parse state to the start of a new string and empties
// the result register.
module hex_dump_message_parser (
  input logic          clk_i,
  input logic          rst_ni,
  hexdmp_char_if.sink  char_i,
  hexdmp_res_if.source res_o
);
  import hexdmp_pkg::*;

  // parse phases
  localparam logic [1:0] PhHigh    = 2'd0;
  localparam logic [1:0] PhLow     = 2'd1;
  localparam logic [1:0] PhDiscard = 2'd2;

  logic [1:0] phase_q, phase_d;
  char_t      pend_q, pend_d;
  count_t     seen_q, seen_d;
  byte_t      opcode_q, opcode_d;
  byte_t      len_q, len_d;

  logic       out_vld_q, out_vld_d;
  kind_e      kind_q, kind_d;
  byte_t      byte_q, byte_d;
  status_e    stat_q, stat_d;
  count_t     cnt_q, cnt_d;

  logic       accept;
  logic       emit;
  char_t      c;
  logic [4:0] hi_dec, lo_dec;
  byte_t      expect_len;
  status_e    end_stat;
  count_t     seen_inc;

  assign char_i.ready = !out_vld_q || res_o.ready;
  assign accept       = char_i.valid && char_i.ready;
  assign c            = char_i.char_code;

  assign hi_dec   = hex_nibble(pend_q);
  assign lo_dec   = hex_nibble(c);
  assign seen_inc = seen_q + count_t'(1);

  // expected length from the opcode class
  always_comb begin
    unique case (opcode_q[6:5])
      LenClass2: expect_len = byte_t'(2);
      LenClass4: expect_len = byte_t'(4);
      LenClass6: expect_len = byte_t'(6);
      default:   expect_len = len_q;
    endcase
  end

  // status at the zero that closes a string
  always_comb begin
    if (seen_q < count_t'(2)) begin
      end_stat = StTooShort;
    end else if (seen_q == count_t'(expect_len)) begin
      end_stat = StOk;
    end else begin
      end_stat = StLenMismatch;
    end
  end

  // phase update and result selection
  always_comb begin
    phase_d  = phase_q;
    pend_d   = pend_q;
    seen_d   = seen_q;
    opcode_d = opcode_q;
    len_d    = len_q;
    emit     = 1'b0;
    kind_d   = KindStatus;
    byte_d   = '0;
    stat_d   = StOk;
    cnt_d    = seen_q;

    if (accept) begin
      unique case (phase_q)
        PhHigh: begin
          if (c == ChNul) begin
            emit     = 1'b1;
            stat_d   = end_stat;
            phase_d  = PhHigh;
            pend_d   = '0;
            seen_d   = '0;
            opcode_d = '0;
            len_d    = '0;
          end else if (c == ChSpace && seen_q != '0) begin
            phase_d = PhHigh;
          end else if (seen_q >= count_t'(MaxBytes)) begin
            emit    = 1'b1;
            stat_d  = StOverflow;
            phase_d = PhDiscard;
          end else begin
            pend_d  = c;
            phase_d = PhLow;
          end
        end
        PhLow: begin
          if (c == ChNul) begin
            emit     = 1'b1;
            stat_d   = StMidByte;
            phase_d  = PhHigh;
            pend_d   = '0;
            seen_d   = '0;
            opcode_d = '0;
            len_d    = '0;
          end else if (!hi_dec[4] || !lo_dec[4]) begin
            emit    = 1'b1;
            stat_d  = StBadHex;
            phase_d = PhDiscard;
          end else begin
            emit    = 1'b1;
            kind_d  = KindData;
            byte_d  = {hi_dec[3:0], lo_dec[3:0]};
            cnt_d   = seen_inc;
            seen_d  = seen_inc;
            phase_d = PhHigh;
            if (seen_q == count_t'(0)) begin
              opcode_d = {hi_dec[3:0], lo_dec[3:0]};
            end else if (seen_q == count_t'(1)) begin
              len_d = {hi_dec[3:0], lo_dec[3:0]};
            end
          end
        end
        default: begin
          // discarding until the closing zero
          if (c == ChNul) begin
            phase_d  = PhHigh;
            pend_d   = '0;
            seen_d   = '0;
            opcode_d = '0;
            len_d    = '0;
          end
        end
      endcase
    end
  end

  // result register valid flag
  always_comb begin
    if (accept) begin
      out_vld_d = emit;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHigh;
      pend_q    <= '0;
      seen_q    <= '0;
      opcode_q  <= '0;
      len_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      pend_q    <= pend_d;
      seen_q    <= seen_d;
      opcode_q  <= opcode_d;
      len_q     <= len_d;
      out_vld_q <= out_vld_d;
    end
  end

  // result payload, loaded with each new result
  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      kind_q <= kind_d;
      byte_q <= byte_d;
      stat_q <= stat_d;
      cnt_q  <= cnt_d;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.result_kind = kind_q;
  assign res_o.data_byte   = byte_q;
  assign res_o.status      = stat_q;
  assign res_o.byte_count  = cnt_q;

endmodule

// ----- tb/sv/hex_dump_message_parser_tb.sv -----
// testbench: hex dump parser checked transaction by transaction against its own predictor
`timescale 1ns / 1ps

module hex_dump_message_parser_tb;
  import hexdmp_pkg::*;

  // run length and pacing
  localparam int unsigned ItemTarget = 900;
  localparam int unsigned CycleLimit = 200_000;
  localparam int unsigned TailCycles = 8;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned LongStr    = 5;
  localparam int unsigned HoldStr    = 10;
  localparam int unsigned DrainStr   = 18;
  localparam int unsigned CalmFirst  = 25;
  localparam int unsigned CalmLast   = 45;

  localparam char_t ChDigit0 = "0";
  localparam char_t ChUpperA = "A";
  localparam char_t ChLowerA = "a";

  typedef enum logic [1:0] {
    PhHigh    = 2'd0,
    PhLow     = 2'd1,
    PhDiscard = 2'd2
  } phase_e;

  typedef struct packed {
    kind_e   kind;
    byte_t   data;
    status_e st;
    count_t  cnt;
  } parse_res_t;

  typedef struct packed {
    char_t      ch;
    bit         typed;
    parse_res_t want;
  } dir_row_t;

  localparam parse_res_t NoRes = '{KindData, 8'h00, StOk, 8'd0};

  // directed rows: empty string, byte extremes, leading space, spaced bytes,
  // zero after a non-hex high character, variable length message
  localparam dir_row_t DirTab [25] = '{
    '{8'h00, 1'b1, '{KindStatus, 8'h00, StTooShort, 8'd0}},
    '{"0",   1'b0, NoRes},
    '{"0",   1'b1, '{KindData, 8'h00, StOk, 8'd1}},
    '{"f",   1'b0, NoRes},
    '{"F",   1'b1, '{KindData, 8'hff, StOk, 8'd2}},
    '{8'h00, 1'b1, '{KindStatus, 8'h00, StOk, 8'd2}},
    '{" ",   1'b0, NoRes},
    '{"1",   1'b1, '{KindStatus, 8'h00, StBadHex, 8'd0}},
    '{8'h00, 1'b0, NoRes},
    '{"2",   1'b0, NoRes},
    '{"0",   1'b1, '{KindData, 8'h20, StOk, 8'd1}},
    '{" ",   1'b0, NoRes},
    '{"0",   1'b0, NoRes},
    '{"5",   1'b1, '{KindData, 8'h05, StOk, 8'd2}},
    '{8'h00, 1'b1, '{KindStatus, 8'h00, StLenMismatch, 8'd2}},
    '{8'hff, 1'b0, NoRes},
    '{8'h00, 1'b1, '{KindStatus, 8'h00, StMidByte, 8'd0}},
    '{"6",   1'b0, NoRes},
    '{"0",   1'b0, NoRes},
    '{" ",   1'b0, NoRes},
    '{"0",   1'b0, NoRes},
    '{"3",   1'b0, NoRes},
    '{"A",   1'b0, NoRes},
    '{"b",   1'b0, NoRes},
    '{8'h00, 1'b0, NoRes}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  hexdmp_char_if char_if ();
  hexdmp_res_if  res_if ();

  hex_dump_message_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .char_i (char_if),
    .res_o  (res_if)
  );

  // predictor state
  phase_e phase;
  char_t  pending;
  count_t bytes_seen;
  byte_t  opcode;
  byte_t  msg_len;

  parse_res_t  due_results [$];
  parse_res_t  head;
  int unsigned fail_count  = 0;
  int unsigned chars_taken = 0;
  int unsigned cycles      = 0;
  bit          calm        = 1'b0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic void clear_string();
    phase      = PhHigh;
    pending    = ChNul;
    bytes_seen = '0;
    opcode     = '0;
    msg_len    = '0;
  endfunction

  function automatic bit hex_value(input char_t c, output logic [3:0] v);
    v = 4'd0;
    if (c >= ChDigit0 && c <= ChDigit0 + 8'd9) begin
      v = 4'(c - ChDigit0);
    end else if (c >= ChLowerA && c <= ChLowerA + 8'd5) begin
      v = 4'(c - ChLowerA + 8'd10);
    end else if (c >= ChUpperA && c <= ChUpperA + 8'd5) begin
      v = 4'(c - ChUpperA + 8'd10);
    end else begin
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic char_t hex_digit(input logic [3:0] n, input bit upper);
    if (n < 4'd10) return ChDigit0 + 8'(n);
    return (upper ? ChUpperA : ChLowerA) + 8'(n) - 8'd10;
  endfunction

  // one character through the parser state; idle marks a skipped space or discard
  function automatic void parse_char(input char_t c, output bit emits, output bit idle,
                                     output parse_res_t r);
    logic [3:0] hi_n, lo_n;
    bit         hi_ok, lo_ok;
    count_t     need;
    emits = 1'b0;
    idle  = 1'b0;
    r     = NoRes;
    case (phase)
      PhHigh: begin
        if (c == ChNul) begin
          // end of string: length check
          emits  = 1'b1;
          r.kind = KindStatus;
          r.cnt  = bytes_seen;
          if (bytes_seen < 2) begin
            r.st = StTooShort;
          end else begin
            case (opcode[6:5])
              LenClass2: need = 8'd2;
              LenClass4: need = 8'd4;
              LenClass6: need = 8'd6;
              default:   need = msg_len;
            endcase
            r.st = (bytes_seen == need) ? StOk : StLenMismatch;
          end
          clear_string();
        end else if (c == ChSpace && bytes_seen != 0) begin
          idle = 1'b1;
        end else if (bytes_seen >= MaxBytes) begin
          emits  = 1'b1;
          r.kind = KindStatus;
          r.st   = StOverflow;
          r.cnt  = bytes_seen;
          phase  = PhDiscard;
        end else begin
          pending = c;
          phase   = PhLow;
        end
      end
      PhLow: begin
        hi_ok  = hex_value(pending, hi_n);
        lo_ok  = hex_value(c, lo_n);
        emits  = 1'b1;
        r.kind = KindStatus;
        r.cnt  = bytes_seen;
        if (c == ChNul) begin
          r.st = StMidByte;
          clear_string();
        end else if (!(hi_ok && lo_ok)) begin
          r.st  = StBadHex;
          phase = PhDiscard;
        end else begin
          r.kind = KindData;
          r.data = {hi_n, lo_n};
          if (bytes_seen == 0) begin
            opcode = r.data;
          end else if (bytes_seen == 1) begin
            msg_len = r.data;
          end
          bytes_seen = bytes_seen + 1'b1;
          r.cnt      = bytes_seen;
          phase      = PhHigh;
        end
      end
      default: begin
        // discarding up to the zero
        idle = 1'b1;
        if (c == ChNul) clear_string();
      end
    endcase
  endfunction

  // offer one character, wait for the transaction, then predict
  task automatic send_char(input char_t ch, input bit typed = 1'b0,
                           input parse_res_t want = '0);
    int unsigned gap;
    bit          emits, idle;
    parse_res_t  got;
    gap = 0;
    while (!calm && $urandom_range(0, 99) < 36) gap++;
    if (gap != 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    char_if.valid     <= 1'b1;
    char_if.char_code <= ch;
    do @(posedge clk_i); while (!char_if.ready);
    parse_char(ch, emits, idle, got);
    if (typed) begin
      due_results.push_back(want);
    end else if (emits) begin
      due_results.push_back(got);
    end
    if (!idle) chars_taken++;
  endtask

  task automatic send_hex_byte(input byte_t b);
    send_char(hex_digit(b[7:4], 1'($urandom_range(0, 1))));
    send_char(hex_digit(b[3:0], 1'($urandom_range(0, 1))));
  endtask

  // receiver: random stalls, a long hold-off on request, none while calm
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen    <= hold_req;
      hold_left    <= HoldCycles;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(0, 99) >= 36);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (res_if.valid && res_if.ready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %0h status %0d count %0d",
               res_if.result_kind, res_if.data_byte, res_if.status, res_if.byte_count);
        fail_count++;
      end else begin
        head = due_results.pop_front();
        if (res_if.result_kind !== head.kind) begin
          $error("result_kind: expected %0d, got %0d", head.kind, res_if.result_kind);
          fail_count++;
        end
        if (res_if.data_byte !== head.data) begin
          $error("data_byte: expected %0h, got %0h", head.data, res_if.data_byte);
          fail_count++;
        end
        if (res_if.status !== head.st) begin
          $error("status: expected %0d, got %0d", head.st, res_if.status);
          fail_count++;
        end
        if (res_if.byte_count !== head.cnt) begin
          $error("byte_count: expected %0d, got %0d", head.cnt, res_if.byte_count);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus
  initial begin
    int unsigned str_idx;
    int unsigned nbytes;
    int unsigned want_len;
    byte_t       opc;
    byte_t       len_byte;
    rst_ni            = 1'b0;
    char_if.valid     = 1'b0;
    char_if.char_code = ChNul;
    res_if.ready      = 1'b0;
    clear_string();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (DirTab[i]) send_char(DirTab[i].ch, DirTab[i].typed, DirTab[i].want);

    // random strings
    str_idx = 0;
    while (chars_taken < ItemTarget) begin
      calm <= (str_idx >= CalmFirst && str_idx < CalmLast);
      if (str_idx == HoldStr) hold_req <= hold_req + 1;
      if (str_idx == DrainStr) begin
        // sender pause until the result queue runs dry
        char_if.valid <= 1'b0;
        do @(posedge clk_i); while (due_results.size() != 0);
      end

      if (str_idx == LongStr) begin
        // full buffer, then one more byte start: overflow
        for (int j = 0; j < MaxBytes; j++) send_hex_byte(byte_t'($urandom_range(0, 255)));
        send_char(ChSpace);
        send_char(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        repeat ($urandom_range(0, 3)) send_char(char_t'($urandom_range(1, 255)));
        send_char(ChNul);
      end else begin
        case ($urandom_range(0, 19)) inside
          [0:12]: begin
            // well-formed message, mostly of the right length
            opc = byte_t'($urandom_range(0, 255));
            len_byte = ($urandom_range(0, 99) < 80) ? byte_t'($urandom_range(2, 12))
                                                    : byte_t'($urandom_range(0, 255));
            case (opc[6:5])
              LenClass2: want_len = 2;
              LenClass4: want_len = 4;
              LenClass6: want_len = 6;
              default:   want_len = len_byte;
            endcase
            if (opc[6:5] != LenClassVar) len_byte = byte_t'($urandom_range(0, 255));
            nbytes = (want_len > 16) ? $urandom_range(2, 16) : want_len;
            if ($urandom_range(0, 99) < 25) nbytes = $urandom_range(0, 8);
            for (int j = 0; j < nbytes; j++) begin
              if (j > 0) repeat ($urandom_range(0, 1)) send_char(ChSpace);
              if (j == 0) begin
                send_hex_byte(opc);
              end else if (j == 1) begin
                send_hex_byte(len_byte);
              end else begin
                send_hex_byte(byte_t'($urandom_range(0, 255)));
              end
            end
            send_char(ChNul);
          end
          [13:16]: begin
            // a few good bytes, then a broken pair
            repeat ($urandom_range(0, 4)) send_hex_byte(byte_t'($urandom_range(0, 255)));
            case ($urandom_range(0, 2))
              0: send_char(char_t'($urandom_range(1, 255)));
              1: begin
                send_char(char_t'($urandom_range(1, 255)));
                send_char(char_t'($urandom_range(1, 255)));
                repeat ($urandom_range(0, 3)) send_char(char_t'($urandom_range(1, 255)));
              end
              default: begin
                send_char(hex_digit(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
                send_char(ChSpace);
              end
            endcase
            send_char(ChNul);
          end
          default: begin
            // noise
            repeat ($urandom_range(0, 8)) send_char(char_t'($urandom_range(1, 255)));
            send_char(ChNul);
          end
        endcase
      end
      str_idx++;
    end

    // drain and finish
    char_if.valid <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
    repeat (TailCycles) @(posedge clk_i);
    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
